### hdl/bdbd_pkg.sv
// ----------------------------------------------------------------------------
// bdbd_pkg: shared types, constants and calendar functions
// Calendar helpers for the business day counter: month lengths, month
// offsets for the March-based serial day, date check and weekday tally.
// ----------------------------------------------------------------------------
package bdbd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CntW   = 22;
  localparam int unsigned MaxYear = 9999;

  // reciprocal divider: quotient = (x * recip) >> RecipShift in one step,
  // remainder = x - quotient * divisor in the next; exact for every
  // dividend used here (years below 2**14, day counts below 2**22)
  localparam int unsigned DivSteps   = 2;
  localparam int unsigned StepW      = $clog2(DivSteps);
  localparam int unsigned RemW       = 7;
  localparam int unsigned CentW      = 8;   // year / 100 for years up to 16383
  localparam int unsigned RecipW     = 23;
  localparam int unsigned RecipShift = 25;

  localparam logic [RemW-1:0] DivCent = RemW'(100);
  localparam logic [RemW-1:0] DivWeek = RemW'(7);

  localparam logic [RecipW-1:0] RecipCent = RecipW'(335545);   // ceil(2**25 / 100)
  localparam logic [RecipW-1:0] RecipWeek = RecipW'(4793491);  // ceil(2**25 / 7)

  // serial day 0 (March 1 of year 0) falls on a Wednesday, Sunday being 0
  localparam logic [2:0] SerialWday = 3'd3;

  localparam logic [MonW-1:0] MonJan = MonW'(1);
  localparam logic [MonW-1:0] MonFeb = MonW'(2);
  localparam logic [MonW-1:0] MonDec = MonW'(12);

  typedef logic [CntW-1:0] count_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(30);
      default:                   len = DayW'(31);
    endcase
    return len;
  endfunction

  // days from March 1 to the first of month m, year taken to start in March
  function automatic logic [8:0] month_off(input logic [MonW-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // cent = year / 100, cent_zero = (year % 100 == 0)
  function automatic logic date_ok(input logic [DayW-1:0]  d,
                                   input logic [MonW-1:0]  m,
                                   input logic [YearW-1:0] y,
                                   input logic [CentW-1:0] cent,
                                   input logic             cent_zero);
    logic leap;
    leap = ((y[1:0] == 2'b00) && !cent_zero) || (cent_zero && (cent[1:0] == 2'b00));
    return (m >= MonJan) && (m <= MonDec) && (y != '0) && (y <= YearW'(MaxYear)) &&
           (d != '0) && (d <= month_len(m, leap));
  endfunction

  // serial day number with the year starting in March; Jan/Feb use year - 1
  function automatic count_t serial_day(input logic [DayW-1:0]  d,
                                        input logic [MonW-1:0]  m,
                                        input logic [YearW-1:0] y,
                                        input logic [CentW-1:0] cent,
                                        input logic             cent_zero);
    logic              early;
    logic [YearW-1:0]  yy;
    logic [YearW-1:0]  y4;
    logic [CentW-1:0]  c1;
    logic [CentW-1:0]  c4;
    early = (m == MonJan) || (m == MonFeb);
    yy = y - YearW'(early);
    y4 = (y >> 2) - YearW'(early && (y[1:0] == 2'b00));
    c1 = cent - CentW'(early && cent_zero);
    c4 = (cent >> 2) - CentW'(early && cent_zero && (cent[1:0] == 2'b00));
    return CntW'(yy) * CntW'(365) + CntW'(y4) - CntW'(c1) + CntW'(c4) +
           CntW'(month_off(m)) + CntW'(d) - CntW'(1);
  endfunction

  // Monday..Friday among r consecutive days starting on weekday w
  function automatic logic [2:0] wd_count(input logic [2:0] w, input logic [2:0] r);
    logic [2:0] n;
    logic [3:0] k;
    n = '0;
    for (int i = 0; i < 7; i++) begin
      k = 4'(w) + 4'(i);
      if (k >= 4'd7) begin
        k = k - 4'd7;
      end
      if ((3'(i) < r) && (k != 4'd0) && (k != 4'd6)) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

### hdl/business_days_between_dates.sv
// ----------------------------------------------------------------------------
// business_days_between_dates: day and weekday counts between two dates
// Checks both dates, turns them into serial day numbers and counts the days
// in [start, end) (+1 with include_end_day) plus the Monday..Friday days among [start, end).
// ----------------------------------------------------------------------------
// done_o pulses after the week and weekday divides, or straight from the compare
//   state when a date is invalid or start is not before end (no week split needed).
// One item at a time: start is taken only in idle, and up to four two-step divides
//   run on one shared reciprocal multiplier; busy drops with done_o.
// Reset (rst_ni low, async): idle, no strobe, include_end_day cleared.
// The receiver cannot stall: each result is valid for the done_o cycle only.

module business_days_between_dates (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: include_end_day
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [bdbd_pkg::DayW-1:0]     start_day_i,
  input  logic [bdbd_pkg::MonW-1:0]     start_month_i,
  input  logic [bdbd_pkg::YearW-1:0]    start_year_i,
  input  logic [bdbd_pkg::DayW-1:0]     end_day_i,
  input  logic [bdbd_pkg::MonW-1:0]     end_month_i,
  input  logic [bdbd_pkg::YearW-1:0]    end_year_i,
  // result
  output logic                          done_o,
  output logic [bdbd_pkg::CntW-1:0]     total_days_o,
  output logic [bdbd_pkg::CntW-1:0]     weekday_count_o,
  output logic                          invalid_o
);

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;  // wait for start
  localparam logic [2:0] StDivSy = 3'd1;  // start year / 100
  localparam logic [2:0] StDivEy = 3'd2;  // end year / 100
  localparam logic [2:0] StSerS  = 3'd3;  // start serial day, start check
  localparam logic [2:0] StSerE  = 3'd4;  // end serial day, end check
  localparam logic [2:0] StCmp   = 3'd5;  // early exits, span n = e - s
  localparam logic [2:0] StDivN  = 3'd6;  // n / 7 -> whole weeks, leftover days
  localparam logic [2:0] StDivW  = 3'd7;  // (s + 3) % 7 -> start weekday

  localparam int unsigned CntW   = bdbd_pkg::CntW;
  localparam int unsigned RemW   = bdbd_pkg::RemW;
  localparam int unsigned CentW  = bdbd_pkg::CentW;
  localparam int unsigned StepW  = bdbd_pkg::StepW;
  localparam int unsigned RecipW = bdbd_pkg::RecipW;

  // Control registers
  logic [2:0]       state_q, state_d;
  logic             done_q,  done_d;
  logic             inc_q;

  // Divider datapath
  logic [CntW-1:0]  num_q, num_d;   // dividend
  logic [CntW-1:0]  quo_q, quo_d;   // quotient from the first step
  logic [RemW-1:0]  div_q, div_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  // Latched dates
  logic [bdbd_pkg::DayW-1:0]  sd_q, sd_d, ed_q, ed_d;
  logic [bdbd_pkg::MonW-1:0]  sm_q, sm_d, em_q, em_d;
  logic [bdbd_pkg::YearW-1:0] sy_q, sy_d, ey_q, ey_d;

  // Intermediate results
  logic [CentW-1:0] qs_q, qs_d, qe_q, qe_d;  // year / 100
  logic             zs_q, zs_d, ze_q, ze_d;  // year % 100 == 0
  logic [CntW-1:0]  s_q, s_d, e_q, e_d;      // serial days; e later holds the span
  logic             vs_q, vs_d, ve_q, ve_d;  // date valid
  logic [CntW-1:0]  q7_q, q7_d;              // whole weeks
  logic [2:0]       r7_q, r7_d;              // leftover days

  // Result registers
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  work_q,  work_d;
  logic             inv_q,   inv_d;

  // --------------------------------------------------------------------------
  // Shared divider: step 0 takes the quotient by reciprocal multiply,
  // step 1 gets the remainder by multiplying back and subtracting
  // --------------------------------------------------------------------------
  logic [RecipW-1:0]      recip;
  logic [CntW+RecipW-1:0] prod;
  logic [CntW-1:0]        quo_nx;
  logic [CntW-1:0]        back;
  logic [RemW-1:0]        rem_nx;
  logic                   div_last;

  assign recip    = (div_q == bdbd_pkg::DivWeek) ? bdbd_pkg::RecipWeek : bdbd_pkg::RecipCent;
  assign prod     = (CntW+RecipW)'(num_q) * (CntW+RecipW)'(recip);
  assign quo_nx   = CntW'(prod >> bdbd_pkg::RecipShift);
  assign back     = quo_q * CntW'(div_q);
  assign rem_nx   = RemW'(num_q - back);
  assign div_last = (cnt_q == StepW'(bdbd_pkg::DivSteps - 1));

  // --------------------------------------------------------------------------
  // Shared serial-day and date-check unit, start date in StSerS else end date
  // --------------------------------------------------------------------------
  logic                       ser_start;
  logic [bdbd_pkg::DayW-1:0]  ser_day;
  logic [bdbd_pkg::MonW-1:0]  ser_mon;
  logic [bdbd_pkg::YearW-1:0] ser_year;
  logic [CentW-1:0]           ser_cent;
  logic                       ser_czero;
  logic [CntW-1:0]            ser_val;
  logic                       ser_ok;

  assign ser_start = (state_q == StSerS);
  assign ser_day   = ser_start ? sd_q : ed_q;
  assign ser_mon   = ser_start ? sm_q : em_q;
  assign ser_year  = ser_start ? sy_q : ey_q;
  assign ser_cent  = ser_start ? qs_q : qe_q;
  assign ser_czero = ser_start ? zs_q : ze_q;
  assign ser_val   = bdbd_pkg::serial_day(ser_day, ser_mon, ser_year, ser_cent, ser_czero);
  assign ser_ok    = bdbd_pkg::date_ok(ser_day, ser_mon, ser_year, ser_cent, ser_czero);

  // Five weekdays per whole week, plus a tally of the leftover days
  logic [CntW-1:0] work_full;
  assign work_full = (q7_q << 2) + q7_q +
                     CntW'(bdbd_pkg::wd_count(rem_nx[2:0], r7_q));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    num_d   = num_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    sd_d = sd_q; sm_d = sm_q; sy_d = sy_q;
    ed_d = ed_q; em_d = em_q; ey_d = ey_q;
    qs_d = qs_q; zs_d = zs_q; qe_d = qe_q; ze_d = ze_q;
    s_d  = s_q;  e_d  = e_q;  vs_d = vs_q; ve_d = ve_q;
    q7_d = q7_q; r7_d = r7_q;
    total_d = total_q;
    work_d  = work_q;
    inv_d   = inv_q;

    case (state_q)
      StIdle: begin
        if (start) begin
          sd_d = start_day_i; sm_d = start_month_i; sy_d = start_year_i;
          ed_d = end_day_i;   em_d = end_month_i;   ey_d = end_year_i;
          num_d   = CntW'(start_year_i);
          cnt_d   = '0;
          div_d   = bdbd_pkg::DivCent;
          state_d = StDivSy;
        end
      end

      StDivSy: begin
        quo_d = quo_nx;
        cnt_d = cnt_q + StepW'(1);
        if (div_last) begin
          qs_d    = quo_q[CentW-1:0];
          zs_d    = (rem_nx == '0);
          num_d   = CntW'(ey_q);
          cnt_d   = '0;
          state_d = StDivEy;
        end
      end

      StDivEy: begin
        quo_d = quo_nx;
        cnt_d = cnt_q + StepW'(1);
        if (div_last) begin
          qe_d    = quo_q[CentW-1:0];
          ze_d    = (rem_nx == '0);
          state_d = StSerS;
        end
      end

      StSerS: begin
        s_d     = ser_val;
        vs_d    = ser_ok;
        state_d = StSerE;
      end

      StSerE: begin
        e_d     = ser_val;
        ve_d    = ser_ok;
        state_d = StCmp;
      end

      StCmp: begin
        if (!(vs_q && ve_q)) begin
          total_d = '0;
          work_d  = '0;
          inv_d   = 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (s_q >= e_q) begin
          total_d = CntW'(inc_q);
          work_d  = '0;
          inv_d   = 1'b0;
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          e_d     = e_q - s_q;
          num_d   = e_q - s_q;
          cnt_d   = '0;
          div_d   = bdbd_pkg::DivWeek;
          state_d = StDivN;
        end
      end

      StDivN: begin
        quo_d = quo_nx;
        cnt_d = cnt_q + StepW'(1);
        if (div_last) begin
          q7_d    = quo_q;
          r7_d    = rem_nx[2:0];
          num_d   = s_q + CntW'(bdbd_pkg::SerialWday);
          cnt_d   = '0;
          state_d = StDivW;
        end
      end

      StDivW: begin
        quo_d = quo_nx;
        cnt_d = cnt_q + StepW'(1);
        if (div_last) begin
          total_d = e_q + CntW'(inc_q);
          work_d  = work_full;
          inv_d   = 1'b0;
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      inc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        inc_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
    sd_q <= sd_d; sm_q <= sm_d; sy_q <= sy_d;
    ed_q <= ed_d; em_q <= em_d; ey_q <= ey_d;
    qs_q <= qs_d; zs_q <= zs_d; qe_q <= qe_d; ze_q <= ze_d;
    s_q  <= s_d;  e_q  <= e_d;  vs_q <= vs_d; ve_q <= ve_d;
    q7_q <= q7_d; r7_q <= r7_d;
    total_q <= total_d;
    work_q  <= work_d;
    inv_q   <= inv_d;
  end

  assign busy            = (state_q != StIdle);
  assign done_o          = done_q;
  assign total_days_o    = total_q;
  assign weekday_count_o = work_q;
  assign invalid_o       = inv_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("start transfer did not launch the sequencer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && invalid_o |-> (total_days_o == '0) && (weekday_count_o == '0))
    else $error("invalid result with nonzero counts");

  a_work_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !invalid_o |-> weekday_count_o <= total_days_o)
    else $error("weekday count exceeds total days");

endmodule
